>>> hdl/asl_pkg.sv
// asl_pkg: constants, codes and types shared by the as-of sample log lookup.
// Depends on nothing. Compile before the interfaces and the core.
package asl_pkg;

    localparam int LOG_DEPTH = 1024;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = IDX_W + 1;

    localparam int STAMP_W = 64;
    localparam int ORD_W   = 64;
    localparam int PRICE_W = 32;
    localparam int SUM_W   = PRICE_W + 1;

    // command codes
    localparam logic [1:0] CMD_RECORD       = 2'd0;
    localparam logic [1:0] CMD_BEFORE       = 2'd1;
    localparam logic [1:0] CMD_AT_OR_BEFORE = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NONE     = 2'd1;
    localparam logic [1:0] STATUS_NO_SIDE  = 2'd2;
    localparam logic [1:0] STATUS_LOG_FULL = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic signed [SUM_W-1:0]  price_sum;
        logic [STAMP_W-1:0]       stamp;
        logic [ORD_W-1:0]         ordinal;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_FINAL  = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

endpackage

>>> hdl/asl_in_if.sv
// asl_in_if: command channel of the sample log (valid/ready plus payload).
// Depends on asl_pkg for field widths.
interface asl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            cmd;
    logic [asl_pkg::STAMP_W-1:0]           stamp;
    logic [asl_pkg::ORD_W-1:0]             ordinal;
    logic                                  bid_present;
    logic signed [asl_pkg::PRICE_W-1:0]    bid_price;
    logic                                  ask_present;
    logic signed [asl_pkg::PRICE_W-1:0]    ask_price;

    modport source (
        output valid, cmd, stamp, ordinal, bid_present, bid_price, ask_present, ask_price,
        input  ready
    );
    modport sink (
        input  valid, cmd, stamp, ordinal, bid_present, bid_price, ask_present, ask_price,
        output ready
    );
endinterface

>>> hdl/asl_out_if.sv
// asl_out_if: result channel of the sample log (valid/ready plus payload).
// Depends on asl_pkg for field widths.
interface asl_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [asl_pkg::SUM_W-1:0]    mid_doubled;

    modport source (
        output valid, status, mid_doubled,
        input  ready
    );
    modport sink (
        input  valid, status, mid_doubled,
        output ready
    );
endinterface

>>> hdl/as_of_sample_log_lookup_core.sv
// as_of_sample_log_lookup_core: sample log with as-of binary search; needs asl_pkg and the channels.
// Flow: record, unused code or query on an empty log: S_IDLE, S_DONE, then the output register;
//   query: S_IDLE, S_SEARCH (at most 11 probes), S_FINAL unless no sample precedes the key, S_DONE.
// Throughput: one item in flight, taken only in S_IDLE; S_DONE waits for a free output register;
//   one probe per cycle on the single read port; a new transfer is taken while a result still waits.
// Reset: asynchronous, active low; clears sequencer, count and result valid; log needs no clearing.
module as_of_sample_log_lookup_core (
    input  logic      clk,
    input  logic      rst_n,
    asl_in_if.sink    req,
    asl_out_if.source rsp
);

    // log memory: one write port (record), one registered read port (search)
    asl_pkg::entry_t mem [asl_pkg::LOG_DEPTH];
    asl_pkg::entry_t rd_data_reg;

    asl_pkg::state_t state_reg, state_next;

    logic [asl_pkg::CNT_W-1:0] count_reg, count_next;
    logic [asl_pkg::CNT_W-1:0] lo_reg, lo_next;
    logic [asl_pkg::CNT_W-1:0] hi_reg, hi_next;
    logic [asl_pkg::CNT_W-1:0] m_reg, m_next;

    // query key and command held during the search
    logic [1:0]                    cmd_reg, cmd_next;
    logic [asl_pkg::STAMP_W-1:0]   key_stamp_reg, key_stamp_next;
    logic [asl_pkg::ORD_W-1:0]     key_ord_reg, key_ord_next;

    // result awaiting the output register
    logic [1:0]                         res_status_reg, res_status_next;
    logic signed [asl_pkg::SUM_W-1:0]   res_mid_reg, res_mid_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic [1:0]                         out_status_reg, out_status_next;
    logic signed [asl_pkg::SUM_W-1:0]   out_mid_reg, out_mid_next;

    logic                        rd_en;
    logic [asl_pkg::IDX_W-1:0]   rd_addr;
    logic                        wr_en;
    asl_pkg::entry_t             wr_entry;

    logic                        in_xfer;
    logic                        out_free;
    logic                        log_full;
    logic                        sample_valid;
    logic                        probe_less;
    logic                        probe_not_above;
    logic                        go_right;
    logic [asl_pkg::CNT_W-1:0]   lo_step, hi_step, m_step;

    assign in_xfer  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign log_full = (count_reg == asl_pkg::CNT_W'(asl_pkg::LOG_DEPTH));

    assign req.ready       = (state_reg == asl_pkg::S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.mid_doubled = out_mid_reg;

    // sample written on a record: doubled mid only when both sides exist
    assign sample_valid = req.bid_present && req.ask_present;
    always_comb
    begin
        wr_entry.valid     = sample_valid;
        wr_entry.stamp     = req.stamp;
        wr_entry.ordinal   = req.ordinal;
        wr_entry.price_sum = sample_valid
                           ? ($signed({req.bid_price[asl_pkg::PRICE_W-1], req.bid_price})
                            + $signed({req.ask_price[asl_pkg::PRICE_W-1], req.ask_price}))
                           : '0;
    end

    // probe compare against the entry read last cycle at m_reg
    // probe_less: entry key strictly below query key
    // probe_not_above: query key not below entry key
    assign probe_less = (rd_data_reg.stamp < key_stamp_reg)
                     || ((rd_data_reg.stamp == key_stamp_reg)
                         && (rd_data_reg.ordinal < key_ord_reg));
    assign probe_not_above = !((key_stamp_reg < rd_data_reg.stamp)
                            || ((key_stamp_reg == rd_data_reg.stamp)
                                && (key_ord_reg < rd_data_reg.ordinal)));
    assign go_right = (cmd_reg == asl_pkg::CMD_BEFORE) ? probe_less : probe_not_above;

    assign lo_step = go_right ? (m_reg + asl_pkg::CNT_W'(1)) : lo_reg;
    assign hi_step = go_right ? hi_reg : m_reg;
    assign m_step  = lo_step + ((hi_step - lo_step) >> 1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        m_next          = m_reg;
        cmd_next        = cmd_reg;
        key_stamp_next  = key_stamp_reg;
        key_ord_next    = key_ord_reg;
        res_status_next = res_status_reg;
        res_mid_next    = res_mid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_mid_next    = out_mid_reg;
        rd_en           = 1'b0;
        rd_addr         = m_reg[asl_pkg::IDX_W-1:0];
        wr_en           = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            asl_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next        = req.cmd;
                    key_stamp_next  = req.stamp;
                    key_ord_next    = req.ordinal;
                    res_status_next = asl_pkg::STATUS_OK;
                    res_mid_next    = '0;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    m_next          = count_reg >> 1;
                    state_next      = asl_pkg::S_DONE;
                    if (req.cmd == asl_pkg::CMD_RECORD)
                    begin
                        if (log_full)
                        begin
                            res_status_next = asl_pkg::STATUS_LOG_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + asl_pkg::CNT_W'(1);
                        end
                    end
                    else if (req.cmd == asl_pkg::CMD_BEFORE
                          || req.cmd == asl_pkg::CMD_AT_OR_BEFORE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = asl_pkg::STATUS_NONE;
                        end
                        else
                        begin
                            // first probe at the middle of [0, count)
                            rd_en      = 1'b1;
                            rd_addr    = m_next[asl_pkg::IDX_W-1:0];
                            state_next = asl_pkg::S_SEARCH;
                        end
                    end
                end
            end

            asl_pkg::S_SEARCH:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                m_next  = m_step;
                if (lo_step < hi_step)
                begin
                    rd_en   = 1'b1;
                    rd_addr = m_step[asl_pkg::IDX_W-1:0];
                end
                else if (lo_step == '0)
                begin
                    res_status_next = asl_pkg::STATUS_NONE;
                    state_next      = asl_pkg::S_DONE;
                end
                else
                begin
                    // candidate is the entry just left of the boundary
                    m_next     = lo_step - asl_pkg::CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = m_next[asl_pkg::IDX_W-1:0];
                    state_next = asl_pkg::S_FINAL;
                end
            end

            asl_pkg::S_FINAL:
            begin
                if (rd_data_reg.valid)
                begin
                    res_status_next = asl_pkg::STATUS_OK;
                    res_mid_next    = rd_data_reg.price_sum;
                end
                else
                begin
                    res_status_next = asl_pkg::STATUS_NO_SIDE;
                end
                state_next = asl_pkg::S_DONE;
            end

            asl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_mid_next    = res_mid_reg;
                    state_next      = asl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = asl_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asl_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and search registers
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        m_reg          <= m_next;
        cmd_reg        <= cmd_next;
        key_stamp_reg  <= key_stamp_next;
        key_ord_reg    <= key_ord_next;
        res_status_reg <= res_status_next;
        res_mid_reg    <= res_mid_next;
        out_status_reg <= out_status_next;
        out_mid_reg    <= out_mid_next;
    end

    // log memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[asl_pkg::IDX_W-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= asl_pkg::CNT_W'(asl_pkg::LOG_DEPTH))
        else $error("log count above depth");

    a_record_appends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && req.cmd == asl_pkg::CMD_RECORD && !log_full)
        |=> (count_reg == $past(count_reg) + asl_pkg::CNT_W'(1)))
        else $error("record transfer did not append");

    a_probe_in_log: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == asl_pkg::S_SEARCH || state_reg == asl_pkg::S_FINAL)
        |-> (m_reg < count_reg))
        else $error("probe beyond stored samples");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == asl_pkg::S_DONE && res_status_reg == asl_pkg::STATUS_LOG_FULL)
        |-> log_full)
        else $error("log full reported with room left");

endmodule
